/* rtl/rrrt_pkg.sv */
// rrrt_pkg: shared constants and codes for the ranging record ring table
// no dependencies; used by the top level and the checker
package rrrt_pkg;

  // operation code carried in the low bits of the input tuser
  typedef logic [1:0] op_t;
  localparam op_t OP_ADD    = 2'd0;
  localparam op_t OP_SEARCH = 2'd1;
  localparam op_t OP_FIND   = 2'd2;
  // unused code: no state change, result none
  localparam op_t OP_NONE   = 2'd3;

  // role bit: receiver or sender rules
  typedef logic role_t;
  localparam role_t ROLE_RX = 1'b0;
  localparam role_t ROLE_TX = 1'b1;

  // input tuser holds op then role
  localparam int OP_BITS   = 2;
  localparam int USER_BITS = OP_BITS + 1;

  // sequence numbers: 17-bit stored form with a null code, 16-bit key
  localparam int SEQ_BITS  = 17;
  localparam int QSEQ_BITS = 16;
  localparam logic [SEQ_BITS-1:0] SEQ_NULL = 17'h10000;

endpackage

/* rtl/ranging_record_ring_table.sv */
// ranging_record_ring_table: ring of ranging records with add, search and find
// add, unused op and any op on an empty ring: no scan, straight to the result;
// search and find: scan every entry from newest to oldest, one record per cycle
// no new item is accepted until the result beat has been issued
// synchronous reset: ring empty, per-entry valid flags cleared
// depends on rrrt_pkg and rrrt_ram
module ranging_record_ring_table #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 40,
  localparam int SW    = $clog2(ENTRIES + 1),
  localparam int DBITS = SW + 3 * TIME_BITS + 2 + 2 * rrrt_pkg::SEQ_BITS + rrrt_pkg::QSEQ_BITS,
  localparam int IN_W  = ((DBITS + 7) / 8) * 8,
  localparam int OUT_W = ((SW + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // slot, tx_time, tx_valid, rx_time, rx_valid, local_seq, remote_seq,
  // query_time, query_seq, zero fill
  input  logic [IN_W-1:0]                s_tdata,
  // op, role
  input  logic [rrrt_pkg::USER_BITS-1:0] s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // result_slot, zero fill
  output logic [OUT_W-1:0]               m_tdata,
  // found
  output logic                           m_tuser
);
  import rrrt_pkg::*;

  localparam int IW    = $clog2(ENTRIES);
  localparam int REC_W = TIME_BITS + 1 + SEQ_BITS;
  localparam logic [SW-1:0] NONE_SLOT = SW'(ENTRIES);
  localparam logic [SW-1:0] LAST_CNT  = SW'(ENTRIES - 1);
  localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);

  // field offsets in s_tdata
  localparam int O_TX   = SW;
  localparam int O_TXV  = O_TX + TIME_BITS;
  localparam int O_RX   = O_TXV + 1;
  localparam int O_RXV  = O_RX + TIME_BITS;
  localparam int O_LSEQ = O_RXV + 1;
  localparam int O_RSEQ = O_LSEQ + SEQ_BITS;
  localparam int O_QT   = O_RSEQ + SEQ_BITS;
  localparam int O_QS   = O_QT + TIME_BITS;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t                state;
  logic [SW-1:0]         newest;
  logic [ENTRIES-1:0]    vld_a;
  logic [ENTRIES-1:0]    vld_b;
  logic                  rd_pend;
  logic [IW-1:0]         rd_idx;
  op_t                   op_q;
  role_t                 role_q;
  logic [TIME_BITS-1:0]  qtime_q;
  logic [QSEQ_BITS-1:0]  qseq_q;
  logic [IW-1:0]         ptr;
  logic [SW-1:0]         cnt;
  logic [SW-1:0]         ans;
  logic [TIME_BITS-1:0]  best;
  logic [SW-1:0]         res_slot;

  // input beat fields
  op_t                   in_op;
  role_t                 in_role;
  logic [SW-1:0]         in_slot;
  logic [TIME_BITS-1:0]  in_tx;
  logic                  in_txv;
  logic [TIME_BITS-1:0]  in_rx;
  logic                  in_rxv;
  logic [SEQ_BITS-1:0]   in_lseq;
  logic [SEQ_BITS-1:0]   in_rseq;
  logic [TIME_BITS-1:0]  in_qt;
  logic [QSEQ_BITS-1:0]  in_qs;

  assign in_op   = s_tuser[OP_BITS-1:0];
  assign in_role = s_tuser[OP_BITS];
  assign in_slot = s_tdata[SW-1:0];
  assign in_tx   = s_tdata[O_TX +: TIME_BITS];
  assign in_txv  = s_tdata[O_TXV];
  assign in_rx   = s_tdata[O_RX +: TIME_BITS];
  assign in_rxv  = s_tdata[O_RXV];
  assign in_lseq = s_tdata[O_LSEQ +: SEQ_BITS];
  assign in_rseq = s_tdata[O_RSEQ +: SEQ_BITS];
  assign in_qt   = s_tdata[O_QT +: TIME_BITS];
  assign in_qs   = s_tdata[O_QS +: QSEQ_BITS];

  // handshake
  logic accept;
  logic out_free;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // next ring slot after the newest record
  logic [IW-1:0] next_idx;
  always_comb begin
    if (newest == NONE_SLOT || newest[IW-1:0] == LAST_IDX) begin
      next_idx = '0;
    end else begin
      next_idx = newest[IW-1:0] + 1'b1;
    end
  end

  // add decode
  logic is_add;
  logic is_patch;
  logic is_append;
  assign is_add    = accept && (in_op == OP_ADD);
  assign is_patch  = is_add && (in_role == ROLE_RX) && (in_slot < NONE_SLOT);
  assign is_append = is_add && !is_patch;

  // record storage: part a is tx side plus remote seq, part b rx side plus local seq
  logic             we_a;
  logic [IW-1:0]    waddr_a;
  logic [REC_W-1:0] rdata_a;
  logic [REC_W-1:0] rdata_b;
  assign we_a    = is_append || is_patch;
  assign waddr_a = is_patch ? in_slot[IW-1:0] : next_idx;

  rrrt_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata ({in_tx, in_txv, in_rseq}),
    .raddr (ptr),
    .rdata (rdata_a)
  );

  rrrt_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram_b (
    .clk   (clk),
    .we    (is_append),
    .waddr (next_idx),
    .wdata ({in_rx, in_rxv, in_lseq}),
    .raddr (ptr),
    .rdata (rdata_b)
  );

  // read record, never-written entries read as null
  logic [TIME_BITS-1:0] rd_tx;
  logic [TIME_BITS-1:0] rd_rx;
  logic                 eff_txv;
  logic                 eff_rxv;
  logic [SEQ_BITS-1:0]  eff_lseq;
  assign rd_tx    = rdata_a[REC_W-1 -: TIME_BITS];
  assign rd_rx    = rdata_b[REC_W-1 -: TIME_BITS];
  assign eff_txv  = vld_a[rd_idx] && rdata_a[SEQ_BITS];
  assign eff_rxv  = vld_b[rd_idx] && rdata_b[SEQ_BITS];
  assign eff_lseq = vld_b[rd_idx] ? rdata_b[SEQ_BITS-1:0] : SEQ_NULL;

  // shared compare unit, one record per cycle
  logic [TIME_BITS-1:0] key;
  logic                 have;
  logic                 take_search;
  logic                 take_find;
  logic                 take;
  assign key  = (role_q == ROLE_RX) ? rd_tx : rd_rx;
  assign have = (ans != NONE_SLOT);
  assign take_search = eff_txv && eff_rxv && (key < qtime_q) && (!have || key > best);
  assign take_find   = (eff_lseq != SEQ_NULL) && (eff_lseq == {1'b0, qseq_q}) && !have;
  assign take = rd_pend && ((op_q == OP_SEARCH) ? take_search : take_find);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      newest   <= NONE_SLOT;
      vld_a    <= '0;
      vld_b    <= '0;
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (we_a) begin
        vld_a[waddr_a] <= 1'b1;
      end
      if (is_append) begin
        vld_b[next_idx] <= 1'b1;
        newest          <= SW'(next_idx);
      end
      rd_pend <= (state == S_SCAN);
      // result beat: raise when the answer is ready, drop once taken
      if (state == S_FIN && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if ((in_op == OP_SEARCH || in_op == OP_FIND) && newest != NONE_SLOT) begin
              state <= S_SCAN;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (cnt == LAST_CNT) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_idx <= ptr;
    if (accept) begin
      op_q    <= in_op;
      role_q  <= in_role;
      qtime_q <= in_qt;
      qseq_q  <= in_qs;
      ptr     <= newest[IW-1:0];
      cnt     <= '0;
      best    <= '0;
      if (is_append && in_role == ROLE_TX) begin
        ans <= SW'(next_idx);
      end else begin
        ans <= NONE_SLOT;
      end
    end
    // walk from newest toward oldest
    if (state == S_SCAN) begin
      ptr <= (ptr == '0) ? LAST_IDX : ptr - 1'b1;
      cnt <= cnt + 1'b1;
    end
    if (take) begin
      ans  <= SW'(rd_idx);
      best <= key;
    end
    if (state == S_FIN && out_free) begin
      res_slot <= ans;
      m_tuser  <= (ans != NONE_SLOT);
    end
  end

  assign m_tdata = OUT_W'(res_slot);

endmodule

/* rtl/rrrt_ram.sv */
// rrrt_ram: generic simple dual-port ram, one write and one registered read
// no dependencies; used for the record storage of the ring table
module rrrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/rrrt_checker.sv */
// rrrt_checker: port-level assertions for the ranging record ring table
// depends on rrrt_pkg; bound to ranging_record_ring_table below
module rrrt_checker #(
  parameter int ENTRIES   = 16,
  parameter int TIME_BITS = 40,
  localparam int SW    = $clog2(ENTRIES + 1),
  localparam int DBITS = SW + 3 * TIME_BITS + 2 + 2 * rrrt_pkg::SEQ_BITS + rrrt_pkg::QSEQ_BITS,
  localparam int IN_W  = ((DBITS + 7) / 8) * 8,
  localparam int OUT_W = ((SW + 7) / 8) * 8
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  // slot, tx_time, tx_valid, rx_time, rx_valid, local_seq, remote_seq,
  // query_time, query_seq, zero fill
  input logic [IN_W-1:0]                s_tdata,
  // op, role
  input logic [rrrt_pkg::USER_BITS-1:0] s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  // result_slot, zero fill
  input logic [OUT_W-1:0]               m_tdata,
  // found
  input logic                           m_tuser
);

  // one item at a time: busy right after every accepted beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in progress");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // found flag agrees with the slot carried in the same beat
  a_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == (m_tdata[SW-1:0] < SW'(ENTRIES))))
    else $error("found flag disagrees with result slot");

  // reset leaves no result pending and the input open
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind ranging_record_ring_table rrrt_checker #(
  .ENTRIES   (ENTRIES),
  .TIME_BITS (TIME_BITS)
) u_rrrt_checker (.*);
